/* design/obl_pkg.sv */
// Shared types and constants for the order-book level table.
`default_nettype none

package obl_pkg;

    // Table geometry.
    localparam int DEPTH   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Field widths of one beat.
    localparam int OPCODE_W = 2;
    localparam int SLOT_W   = 6;
    localparam int PRICE_W  = 32;
    localparam int AMOUNT_W = 31;
    localparam int STATUS_W = 2;
    localparam int LCOUNT_W = 6;
    localparam int DATA_W   = 72;

    // Width that holds both a slot and a count plus one without overflow.
    localparam int CMP_W = ((SLOT_W > COUNT_W) ? SLOT_W : COUNT_W) + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_POS   = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    // One price level.
    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [PRICE_W-1:0]  price;
    } level_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             upd;
        logic             del;
        logic [IDX_W-1:0] pos0;
        level_t           data;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* design/order_book_level_table.sv */
// Top level of the order-book level table: command decode, cell chain and result register.
//
// Usage: commands enter on the s_ group, one beat per operation (insert,
// update, delete or read of a 1-based position). Each command yields
// exactly one result beat on the m_ group carrying a status, the level at
// the addressed position after the operation, and the number of levels.
// The book is a row of level cells; insert and delete shift every cell
// after the addressed position by one place in the accept cycle.
// The result beat is registered: an accepted command moves the control
// to the response state, in which the addressed cell is selected into
// the result register; no new command is accepted in that state, so a
// command is not taken before the previous one has reached the result register.
// When the receiver stalls, the result holds in the output register and
// no new command is accepted until it is taken; a command can be
// accepted in the same cycle the previous result is taken.
// Reset empties the book (count zero), returns the control to idle and
// clears the result valid flag.
`default_nettype none

module order_book_level_table
    import obl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // opcode[1:0], slot[7:2], price[39:8], amount[70:40], zero pad[71]
    input  wire logic [DATA_W-1:0] s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // status[1:0], read_price[33:2], read_amount[64:34], level_count[70:65], zero pad[71]
    output logic [DATA_W-1:0]      m_tdata
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t              state_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SLOT_W-1:0]   slot_reg;
    status_t             status_reg;
    status_t             status_next;
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;

    op_t                 in_op;
    logic [SLOT_W-1:0]   in_slot;
    logic [CMP_W-1:0]    slot_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                accept;
    logic                slot_zero;
    logic                bad_ins;
    logic                miss;
    logic                full;
    cell_cmd_t           cmd;

    level_t              levels [DEPTH];
    level_t              rd_level;
    logic                rd_hit;
    logic [SLOT_W-1:0]   slot_m1;

    // Field extraction and range checks against the current count.
    assign in_op     = op_t'(s_tdata[1:0]);
    assign in_slot   = s_tdata[7:2];
    assign slot_ext  = CMP_W'(in_slot);
    assign cnt_ext   = CMP_W'(count_reg);
    assign slot_zero = (in_slot == '0);
    assign bad_ins   = slot_zero || (slot_ext > (cnt_ext + CMP_W'(1)));
    assign miss      = slot_zero || (slot_ext > cnt_ext);
    assign full      = (count_reg == COUNT_W'(DEPTH));

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Decode the operation into a status, a cell command and the new count.
    always_comb
    begin
        status_next    = STS_OK;
        count_next     = count_reg;
        cmd.ins        = 1'b0;
        cmd.upd        = 1'b0;
        cmd.del        = 1'b0;
        cmd.pos0       = IDX_W'(in_slot - SLOT_W'(1));
        cmd.data.price = s_tdata[39:8];
        cmd.data.amount = s_tdata[70:40];
        unique case (in_op)
            OP_INSERT:
            begin
                if (bad_ins)
                begin
                    status_next = STS_BAD_POS;
                end
                else if (full)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_UPDATE:
            begin
                if (miss)
                begin
                    status_next = STS_NOT_FOUND;
                end
                else
                begin
                    cmd.upd = accept;
                end
            end
            OP_DELETE:
            begin
                if (miss)
                begin
                    status_next = STS_NOT_FOUND;
                end
                else
                begin
                    cmd.del    = accept;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (miss)
                begin
                    status_next = STS_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
    end

    // Chain of level cells; the ends are tied back to themselves.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        level_t left_lvl;
        level_t right_lvl;

        if (g == 0)
        begin : g_first
            assign left_lvl = levels[g];
        end
        else
        begin : g_mid_l
            assign left_lvl = levels[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_lvl = levels[g];
        end
        else
        begin : g_mid_r
            assign right_lvl = levels[g+1];
        end

        obl_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(g)),
            .cmd   (cmd),
            .left  (left_lvl),
            .right (right_lvl),
            .level (levels[g])
        );
    end

    // Select the addressed level after the operation has settled in the cells.
    assign slot_m1  = slot_reg - SLOT_W'(1);
    assign rd_hit   = (slot_reg != '0) && (CMP_W'(slot_reg) <= CMP_W'(count_reg));
    assign rd_level = rd_hit ? levels[IDX_W'(slot_m1)] : '0;

    // Control state, count and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            slot_reg     <= '0;
            status_reg   <= STS_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg  <= ST_RESP;
                        count_reg  <= count_next;
                        slot_reg   <= in_slot;
                        status_reg <= status_next;
                    end
                end
                ST_RESP:
                begin
                    state_reg    <= ST_IDLE;
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= {1'b0, LCOUNT_W'(count_reg), rd_level.amount,
                                     rd_level.price, status_reg};
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // The count never exceeds the table depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("level count above depth");

    // The count moves only on an accepted command.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("level count changed without a command");

    // Every accepted command produces a valid result after its response state.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 m_tvalid)
        else $error("result beat missing after accepted command");

    // A failed command leaves the count unchanged.
    a_fail_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (status_next != STS_OK) |=> (count_reg == $past(count_reg)))
        else $error("failed command changed the count");
`endif

endmodule

`default_nettype wire

/* design/obl_cell.sv */
// One level cell of the book: holds a price and a quantity and shifts with its neighbors.
`default_nettype none

module obl_cell
    import obl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [IDX_W-1:0] idx,
    input  wire cell_cmd_t  cmd,
    input  wire level_t     left,
    input  wire level_t     right,
    output level_t          level
);

    level_t lvl_reg;
    level_t lvl_next;

    // Insert pulls from the left neighbor, delete pulls from the right one.
    always_comb
    begin
        lvl_next = lvl_reg;
        if (cmd.ins)
        begin
            if (idx > cmd.pos0)
            begin
                lvl_next = left;
            end
            else if (idx == cmd.pos0)
            begin
                lvl_next = cmd.data;
            end
        end
        else if (cmd.del)
        begin
            if (idx >= cmd.pos0)
            begin
                lvl_next = right;
            end
        end
        else if (cmd.upd && (idx == cmd.pos0))
        begin
            if (cmd.data.amount != '0)
            begin
                lvl_next.amount = cmd.data.amount;
            end
            if (cmd.data.price != '0)
            begin
                lvl_next.price = cmd.data.price;
            end
        end
    end

    // Level contents need no reset: entries beyond the count are never reported.
    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
    end

    assign level = lvl_reg;

endmodule

`default_nettype wire

/* tb/tb_order_book_level_table.sv */
// Self-checking testbench for the order-book level table: book tracker, stream drivers and checks.
`timescale 1ns / 100ps

module tb_order_book_level_table;
    import obl_pkg::*;

    // One result beat as the block should present it.
    typedef struct {
        status_t             status;
        logic [PRICE_W-1:0]  price;
        logic [AMOUNT_W-1:0] amount;
        logic [LCOUNT_W-1:0] levels;
    } book_result_t;

    // Tracks the contents of the book from accepted commands and checks each result beat.
    class level_book_tracker;
        logic [PRICE_W-1:0]  level_price [DEPTH];
        logic [AMOUNT_W-1:0] level_amount [DEPTH];
        int                  levels;
        book_result_t        pending_results [$];
        int                  errors;

        function new();
            levels = 0;
            errors = 0;
        endfunction

        // Apply one accepted command beat to the book and queue the result it should produce.
        function void note_command(logic [DATA_W-1:0] beat);
            op_t                 op;
            int                  slot;
            int                  i;
            logic [PRICE_W-1:0]  price;
            logic [AMOUNT_W-1:0] amount;
            book_result_t        res;

            op     = op_t'(beat[1:0]);
            slot   = int'(beat[7:2]);
            price  = beat[39:8];
            amount = beat[70:40];
            res.status = STS_OK;

            if (op == OP_INSERT) begin
                if (slot == 0 || slot > levels + 1) begin
                    res.status = STS_BAD_POS;
                end
                else if (levels >= DEPTH) begin
                    res.status = STS_FULL;
                end
                else begin
                    // Open a gap at the position by moving later levels down.
                    for (i = levels; i > slot - 1; i--) begin
                        level_price[i]  = level_price[i - 1];
                        level_amount[i] = level_amount[i - 1];
                    end
                    level_price[slot - 1]  = price;
                    level_amount[slot - 1] = amount;
                    levels++;
                end
            end
            else if (slot == 0 || slot > levels) begin
                res.status = STS_NOT_FOUND;
            end
            else if (op == OP_UPDATE) begin
                // A zero field leaves the stored value alone.
                if (amount != '0)
                    level_amount[slot - 1] = amount;
                if (price != '0)
                    level_price[slot - 1] = price;
            end
            else if (op == OP_DELETE) begin
                // Close the gap by moving later levels up.
                for (i = slot - 1; i + 1 < levels; i++) begin
                    level_price[i]  = level_price[i + 1];
                    level_amount[i] = level_amount[i + 1];
                end
                levels--;
            end

            // Report the level now at the position, or zeros when it is empty.
            res.levels = LCOUNT_W'(levels);
            if (slot >= 1 && slot <= levels) begin
                res.price  = level_price[slot - 1];
                res.amount = level_amount[slot - 1];
            end
            else begin
                res.price  = '0;
                res.amount = '0;
            end
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // Compare one result beat with the oldest queued result.
        function void check_result(logic [DATA_W-1:0] beat);
            book_result_t want;

            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat %h with no command waiting for it", $time, beat);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, beat[1:0]);
            compare_field("read_price", want.price, beat[33:2]);
            compare_field("read_amount", want.amount, beat[64:34]);
            compare_field("level_count", want.levels, beat[70:65]);
        endfunction
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    level_book_tracker book;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_left      = 0;
    logic              hold_req       = 1'b0;
    int                items_sent     = 0;
    int                results_seen   = 0;
    logic              fill_mode      = 1'b1;
    int                phase;

    order_book_level_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off counted here when requested.
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_left = 80;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor both streams; commands are noted before results are checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                book.note_command(s_tdata);
            if (m_tvalid && m_tready) begin
                book.check_result(m_tdata);
                results_seen++;
            end
        end
    end

    // Offer one command beat, with random idle cycles first, and wait until it is taken.
    task automatic send_command(op_t op, int slot, logic [PRICE_W-1:0] price,
                                logic [AMOUNT_W-1:0] amount);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, amount, price, SLOT_W'(slot), op};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Stop sending and wait until every result has come back.
    task automatic wait_book_settled();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_seen < items_sent);
    endtask

    // One random command, steered to fill the book up to full and then drain it.
    task automatic random_command();
        int                  cnt;
        int                  slot;
        int                  pick;
        op_t                 op;
        logic [PRICE_W-1:0]  price;
        logic [AMOUNT_W-1:0] amount;

        cnt = book.levels;
        if (cnt == 0)
            fill_mode = 1'b1;
        else if (cnt >= DEPTH && $urandom_range(7) == 0)
            fill_mode = 1'b0;
        else if ($urandom_range(99) == 0)
            fill_mode = !fill_mode;

        pick = $urandom_range(99);
        if (fill_mode)
            op = (pick < 55) ? OP_INSERT : (pick < 70) ? OP_UPDATE :
                 (pick < 80) ? OP_DELETE : OP_READ;
        else
            op = (pick < 10) ? OP_INSERT : (pick < 25) ? OP_UPDATE :
                 (pick < 80) ? OP_DELETE : OP_READ;

        // Mostly positions that exist, some zero and some anywhere in the field.
        pick = $urandom_range(99);
        if (pick < 8)
            slot = 0;
        else if (pick < 20)
            slot = $urandom_range(63);
        else if (op == OP_INSERT)
            slot = $urandom_range(cnt + 1, 1);
        else
            slot = $urandom_range((cnt > 0) ? cnt : 1, 1);

        pick  = $urandom_range(9);
        price = (pick == 0) ? '0 : (pick == 1) ? '1 : PRICE_W'($urandom);
        pick   = $urandom_range(9);
        amount = (pick == 0) ? '0 : (pick == 1) ? '1 : AMOUNT_W'($urandom);

        send_command(op, slot, price, amount);
    endtask

    // Main sequence: reset, directed cases, then random phases with different idling.
    initial
    begin
        book = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty book: lookups miss and inserts beyond the end are rejected.
        send_command(OP_READ,   1,  32'd1, 31'd1);
        send_command(OP_DELETE, 0,  '1, '1);
        send_command(OP_UPDATE, 1,  32'd5, 31'd5);
        send_command(OP_INSERT, 0,  32'd7, 31'd7);
        send_command(OP_INSERT, 2,  32'd7, 31'd7);
        // Build three levels, extremes of price and amount among them.
        send_command(OP_INSERT, 1,  '1, '1);
        send_command(OP_INSERT, 1,  '0, '0);
        send_command(OP_INSERT, 3,  32'd12345, 31'd7);
        send_command(OP_INSERT, 63, 32'd9, 31'd9);
        send_command(OP_READ,   2,  '0, '0);
        send_command(OP_READ,   63, '1, '1);
        // Updates: both zero keeps all, then price only, amount only, both.
        send_command(OP_UPDATE, 2,  '0, '0);
        send_command(OP_UPDATE, 2,  32'd5, '0);
        send_command(OP_UPDATE, 3,  '0, 31'd9);
        send_command(OP_UPDATE, 1,  32'hAAAA_AAAA, 31'h5555_5555);
        send_command(OP_UPDATE, 4,  32'd1, 31'd1);
        // Deletes: the last level leaves an empty slot, the first pulls the next one up.
        send_command(OP_DELETE, 3,  '0, '0);
        send_command(OP_DELETE, 1,  '0, '0);
        send_command(OP_DELETE, 2,  '0, '0);
        send_command(OP_READ,   0,  '0, '0);
        send_command(OP_INSERT, 2,  32'h8000_0000, 31'h4000_0000);
        send_command(OP_READ,   2,  '0, '0);
        wait_book_settled();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            // Long receiver hold-off while commands keep coming, to back up the input.
            if (phase == 0) begin
                @(negedge clk);
                hold_req = 1'b1;
                @(posedge clk);
            end
            repeat (170) random_command();
            wait_book_settled();
        end

        // Let any stray result beat show up before the verdict.
        repeat (8) @(posedge clk);
        if (book.pending_results.size() != 0) begin
            book.errors++;
            $display("%0t: %0d result beats never arrived", $time,
                     book.pending_results.size());
        end
        if (book.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
